@@ hdl/ght_pkg.sv @@
package ght_pkg;

    // Table geometry
    localparam int DEFAULT_NUM_SLOTS = 16;
    localparam int GEN_W             = 16;
    localparam int TAG_W             = 32;
    localparam int HANDLE_W          = 64;
    localparam int SLOT_FIELD_W      = 32;
    localparam int COUNT_OUT_W       = 5;

    // Operation codes
    localparam logic [1:0] OP_INIT     = 2'd0;
    localparam logic [1:0] OP_SHUTDOWN = 2'd1;
    localparam logic [1:0] OP_REGISTER = 2'd2;
    localparam logic [1:0] OP_LOOKUP   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ALREADY_ON = 3'd1;
    localparam logic [2:0] ST_NOT_ON     = 3'd2;
    localparam logic [2:0] ST_BAD_ARG    = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd5;

    typedef struct packed {
        logic [1:0]          operation;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    device_tag;
    } ght_in_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [HANDLE_W-1:0]    new_handle;
        logic [TAG_W-1:0]       found_tag;
        logic [COUNT_OUT_W-1:0] active_count;
    } ght_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } ght_cmd_t;

endpackage

@@ hdl/ght_ctrl.sv @@
module ght_ctrl
    import ght_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ght_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Commands: capture on input transaction, commit when the output slot is free or being taken
    always_comb begin
        cmd.capture = s_valid && (state_reg == ST_IDLE);
        cmd.commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    end

    // Next state and output valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hdl/ght_datapath.sv @@
module ght_datapath
    import ght_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  ght_in_t  in_data,
    input  ght_cmd_t cmd,
    output ght_out_t out_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_SLOTS);

    // Slots are only ever claimed in order and all freed together, so the
    // occupied slots are always 0 .. count-1 and the next free slot is count.
    // hwm marks how many generation entries were written since init; entries
    // at or above it read as zero.
    logic             enabled_reg, enabled_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] hwm_reg, hwm_next;

    // Stores
    logic [GEN_W-1:0] gen_mem [NUM_SLOTS];
    logic [TAG_W-1:0] tag_mem [NUM_SLOTS];

    // Captured transaction and registered store reads
    ght_in_t          in_reg;
    logic [GEN_W-1:0] gen_rd_reg;
    logic [TAG_W-1:0] tag_rd_reg;
    ght_out_t         result_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] claim_slot;
    logic              wr_en;
    logic [GEN_W-1:0]  gen_eff;
    logic [GEN_W-1:0]  gen_new;
    logic [SLOT_FIELD_W-1:0] lk_slot;
    logic [GEN_W-1:0]  lk_gen;
    ght_out_t          result;

    assign claim_slot = count_reg[SLOT_W-1:0];
    assign rd_addr    = (in_data.operation == OP_REGISTER) ? claim_slot
                                                           : in_data.handle[SLOT_W-1:0];
    assign lk_slot    = in_reg.handle[SLOT_FIELD_W-1:0];
    assign lk_gen     = in_reg.handle[SLOT_FIELD_W +: GEN_W];

    // Capture and store read
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg     <= in_data;
            gen_rd_reg <= gen_mem[rd_addr];
            tag_rd_reg <= tag_mem[rd_addr];
        end
    end

    // Execute the captured operation
    always_comb begin
        enabled_next = enabled_reg;
        count_next   = count_reg;
        hwm_next     = hwm_reg;
        wr_en        = 1'b0;
        gen_eff      = '0;
        gen_new      = '0;
        result       = '0;
        unique case (in_reg.operation)
            OP_INIT: begin
                if (enabled_reg) begin
                    result.status = ST_ALREADY_ON;
                end else begin
                    enabled_next = 1'b1;
                    count_next   = '0;
                    hwm_next     = '0;
                end
            end
            OP_SHUTDOWN: begin
                if (!enabled_reg) begin
                    result.status = ST_NOT_ON;
                end else begin
                    enabled_next = 1'b0;
                    count_next   = '0;
                end
            end
            OP_REGISTER: begin
                gen_eff = (count_reg < hwm_reg) ? gen_rd_reg : '0;
                gen_new = gen_eff + GEN_W'(1);
                if (gen_new == '0) begin
                    gen_new = GEN_W'(1);
                end
                if (in_reg.device_tag == '0) begin
                    result.status = ST_BAD_ARG;
                end else if (!enabled_reg) begin
                    result.status = ST_NOT_ON;
                end else if (count_reg == FULL_COUNT) begin
                    result.status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == hwm_reg) begin
                        hwm_next = hwm_reg + CNT_W'(1);
                    end
                    result.new_handle = {{(HANDLE_W - GEN_W - SLOT_FIELD_W){1'b0}},
                                         gen_new, SLOT_FIELD_W'(count_reg)};
                end
            end
            OP_LOOKUP: begin
                gen_eff = (lk_slot < SLOT_FIELD_W'(hwm_reg)) ? gen_rd_reg : '0;
                if (in_reg.handle == '0) begin
                    result.status = ST_BAD_ARG;
                end else if (!enabled_reg) begin
                    result.status = ST_NOT_ON;
                end else if (lk_slot >= SLOT_FIELD_W'(NUM_SLOTS)
                             || lk_slot >= SLOT_FIELD_W'(count_reg)
                             || gen_eff != lk_gen) begin
                    result.status = ST_BAD_HANDLE;
                end else begin
                    result.found_tag = tag_rd_reg;
                end
            end
            default: result.status = ST_OK;
        endcase
        result.active_count = COUNT_OUT_W'(count_next);
    end

    // Store write
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            gen_mem[claim_slot] <= gen_new;
            tag_mem[claim_slot] <= in_reg.device_tag;
        end
    end

    // Table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            count_reg   <= '0;
            hwm_reg     <= '0;
        end else if (cmd.commit) begin
            enabled_reg <= enabled_next;
            count_reg   <= count_next;
            hwm_reg     <= hwm_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            result_reg <= result;
        end
    end

    assign out_data = result_reg;

    // Checks
    a_count_le_hwm: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hwm_reg)
        else $error("occupied count above written mark");

    a_hwm_le_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        hwm_reg <= FULL_COUNT)
        else $error("written mark beyond table depth");

    a_off_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !enabled_reg |-> count_reg == '0)
        else $error("slots occupied while table disabled");

    a_claim_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("register did not claim exactly one slot");

endmodule

@@ hdl/generational_handle_table.sv @@
// Generational handle table.
// Input channel s_valid/s_ready/s_data carries one operation per transaction:
// init, shutdown, register (claims the lowest free slot, bumps its 16-bit
// generation skipping zero, stores the tag) or lookup (validates a handle
// and returns its tag). Output channel m_valid/m_ready/m_data returns one
// result per operation with status, issued handle, found tag and the
// occupied count after the operation.
// The generation and tag stores are read into registers when the input is
// captured; the update and write-back follow in the execute state, which
// commits the result to the output register. No new item is accepted
// until the execute state has committed the previous one.
// While a result waits for m_ready the next item may be accepted; it then
// holds in the execute stage until the output register is taken.
// Reset (aresetn low, synchronous) disables the table, empties it and zeroes
// all generations; no clearing pass is needed, the generation store reads
// as zero above a written-entries mark. The tag store is not cleared.
module generational_handle_table
    import ght_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ght_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ght_out_t m_data
);

    ght_cmd_t cmd;

    ght_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ght_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .out_data (m_data)
    );

endmodule
